@@ rtl/core/afrr_pkg.sv @@
package afrr_pkg;

   localparam int RING_DEPTH = 256;
   localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int FREE_W     = IDX_W + 1;
   localparam int CMP_W      = (FREE_W > 8) ? FREE_W : 8;

   localparam logic [FREE_W-1:0] DEPTH_EXT = FREE_W'(RING_DEPTH);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(RING_DEPTH - 1);

   // configuration register indexes
   localparam logic CSR_NODE_ADDR  = 1'b0;
   localparam logic CSR_BCAST_ADDR = 1'b1;

   // request opcodes
   localparam logic OP_RX_BYTE = 1'b0;
   localparam logic OP_POP     = 1'b1;

   // response kinds
   localparam logic KIND_POP    = 1'b0;
   localparam logic KIND_NOTICE = 1'b1;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [7:0]       wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic       pop;
      logic       pop_hit;
      logic       notice;
      logic [7:0] notice_len;
   } ctrl_evt_type;

endpackage

@@ rtl/core/afrr_ring_ram.sv @@
module afrr_ring_ram (
   input  logic                                 clock,
   input  afrr_pkg::ram_req_type                ram_req,
   output logic [7:0]                           rd_data
);

   logic [7:0] mem [afrr_pkg::RING_DEPTH];

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data <= mem[ram_req.rd_addr];
      end
   end

endmodule

@@ rtl/core/afrr_ctrl.sv @@
module afrr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [7:0]            csr_wdata,
   input  logic                  item_valid,
   input  logic                  opcode,
   input  logic                  frame_start,
   input  logic [7:0]            rx_byte,
   output afrr_pkg::ram_req_type ram_req,
   output afrr_pkg::ctrl_evt_type evt
);

   typedef enum logic [3:0] {
      PH_LEN   = 4'b0001,
      PH_DEST  = 4'b0010,
      PH_STORE = 4'b0100,
      PH_DROP  = 4'b1000
   } rx_phase_type;

   rx_phase_type                 phase_ff, phase_in;
   logic [afrr_pkg::IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [afrr_pkg::IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [7:0]                   remain_ff, remain_in;
   logic [7:0]                   flen_ff, flen_in;
   logic [7:0]                   node_ff, node_in;
   logic [7:0]                   bcast_ff, bcast_in;

   logic [afrr_pkg::FREE_W-1:0]  free_raw;
   logic [afrr_pkg::FREE_W-1:0]  free_space;
   logic                         fits;
   logic                         addr_match;
   logic [7:0]                   remain_dec;
   logic                         ring_empty;

   function automatic logic [afrr_pkg::IDX_W-1:0] next_ptr(
      input logic [afrr_pkg::IDX_W-1:0] p
   );
      return (p == afrr_pkg::LAST_IDX) ? '0 : p + 1'b1;
   endfunction

   // free slots, keeping one slot empty
   assign free_raw   = {1'b0, rd_ptr_ff} + afrr_pkg::DEPTH_EXT - {1'b0, wr_ptr_ff}
                       - afrr_pkg::FREE_W'(1);
   assign free_space = (free_raw >= afrr_pkg::DEPTH_EXT) ? free_raw - afrr_pkg::DEPTH_EXT
                                                         : free_raw;
   assign fits       = afrr_pkg::CMP_W'(flen_ff) <= afrr_pkg::CMP_W'(free_space);
   assign addr_match = (rx_byte == node_ff) || (rx_byte == bcast_ff);
   assign remain_dec = remain_ff - 8'd1;
   assign ring_empty = (rd_ptr_ff == wr_ptr_ff);

   always_comb begin
      node_in  = node_ff;
      bcast_in = bcast_ff;
      if (csr_we) begin
         unique case (csr_index)
            afrr_pkg::CSR_NODE_ADDR:  node_in  = csr_wdata;
            afrr_pkg::CSR_BCAST_ADDR: bcast_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      rd_ptr_in  = rd_ptr_ff;
      wr_ptr_in  = wr_ptr_ff;
      remain_in  = remain_ff;
      flen_in    = flen_ff;
      ram_req    = '{wr_en: 1'b0, wr_addr: wr_ptr_ff, wr_data: rx_byte,
                     rd_en: 1'b0, rd_addr: rd_ptr_ff};
      evt        = '{pop: 1'b0, pop_hit: 1'b0, notice: 1'b0, notice_len: flen_ff};
      if (item_valid) begin
         if (opcode == afrr_pkg::OP_POP) begin
            evt.pop       = 1'b1;
            evt.pop_hit   = !ring_empty;
            ram_req.rd_en = !ring_empty;
            if (!ring_empty) begin
               rd_ptr_in = next_ptr(rd_ptr_ff);
            end
         end else if (frame_start) begin
            // length byte restarts framing
            if (rx_byte == 8'd0) begin
               phase_in  = PH_LEN;
               remain_in = 8'd0;
            end else begin
               flen_in   = rx_byte - 8'd1;
               remain_in = rx_byte - 8'd1;
               phase_in  = PH_DEST;
            end
         end else begin
            unique case (phase_ff)
               PH_DEST: begin
                  if (addr_match && fits) begin
                     if (remain_ff == 8'd0) begin
                        phase_in   = PH_LEN;
                        evt.notice = 1'b1;
                     end else begin
                        phase_in = PH_STORE;
                     end
                  end else begin
                     phase_in = (remain_ff == 8'd0) ? PH_LEN : PH_DROP;
                  end
               end
               PH_STORE: begin
                  ram_req.wr_en = 1'b1;
                  wr_ptr_in     = next_ptr(wr_ptr_ff);
                  remain_in     = remain_dec;
                  if (remain_dec == 8'd0) begin
                     phase_in   = PH_LEN;
                     evt.notice = 1'b1;
                  end
               end
               PH_DROP: begin
                  remain_in = remain_dec;
                  if (remain_dec == 8'd0) begin
                     phase_in = PH_LEN;
                  end
               end
               PH_LEN: ;
               default: phase_in = PH_LEN;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LEN;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         remain_ff <= 8'd0;
         flen_ff   <= 8'd0;
         node_ff   <= 8'd0;
         bcast_ff  <= 8'd0;
      end else begin
         phase_ff  <= phase_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         remain_ff <= remain_in;
         flen_ff   <= flen_in;
         node_ff   <= node_in;
         bcast_ff  <= bcast_in;
      end
   end

endmodule

@@ rtl/core/addressed_frame_receive_ring.sv @@
// Channel  Direction  Payload
// req      in         tdata[7:0] rx_byte; tuser[0] opcode, tuser[1] frame_start
// rsp      out        tdata[7:0] read_data, tdata[15:8] packet_length;
//                     tuser[0] result_kind, tuser[1] read_valid
// csr      in         csr_index 0 node address, 1 broadcast address
//
// Frame bytes may follow back to back while the output register accepts; a
// pop holds off requests, as its answer waits for the registered ring read.
// Reset is synchronous; the ring contents are not cleared and need no sweep.
// A result waits in the output register; a new transaction is taken when
// that register is empty or drains in the same cycle, and no pop is pending.
module addressed_frame_receive_ring (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   input  logic [1:0]  req_tuser,   // opcode, frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // read_data, packet_length
   output logic [1:0]  rsp_tuser,   // result_kind, read_valid
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   afrr_pkg::ram_req_type  ram_req;
   afrr_pkg::ctrl_evt_type evt;
   logic [7:0]             rd_data;
   logic                   accept;

   logic                   pop_pending_ff, pop_pending_in;
   logic                   pop_hit_ff, pop_hit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]            rsp_data_ff, rsp_data_in;
   logic [1:0]             rsp_user_ff, rsp_user_in;

   // hold off new transactions while a pop waits for ring data
   assign req_tready = !pop_pending_ff && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   afrr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .item_valid  (accept),
      .opcode      (req_tuser[0]),
      .frame_start (req_tuser[1]),
      .rx_byte     (req_tdata),
      .ram_req     (ram_req),
      .evt         (evt)
   );

   afrr_ring_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   always_comb begin
      pop_pending_in = evt.pop;
      pop_hit_in     = evt.pop_hit;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;
      if (pop_pending_ff) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {8'd0, pop_hit_ff ? rd_data : 8'd0};
         rsp_user_in  = {pop_hit_ff, afrr_pkg::KIND_POP};
      end else if (evt.notice) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {evt.notice_len, 8'd0};
         rsp_user_in  = {1'b0, afrr_pkg::KIND_NOTICE};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pop_pending_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         pop_pending_ff <= pop_pending_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      pop_hit_ff  <= pop_hit_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef NO_ASSERTIONS
   a_pop_blocks_req: assert property (@(posedge clock) disable iff (reset)
      pop_pending_ff |-> !req_tready)
      else $error("transaction taken while a pop waits for ring data");

   a_pop_pends: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser[0] == afrr_pkg::OP_POP) |=> pop_pending_ff)
      else $error("pop transaction did not start a ring read");

   a_pop_answers: assert property (@(posedge clock) disable iff (reset)
      pop_pending_ff |=> (rsp_tvalid && rsp_tuser[0] == afrr_pkg::KIND_POP))
      else $error("pending pop did not reach the output register");

   a_notice_no_collide: assert property (@(posedge clock) disable iff (reset)
      pop_pending_ff |-> !evt.notice)
      else $error("notice raised while a pop answer is being loaded");
`endif

endmodule
